// File: src/hpt_pkg.sv
package hpt_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_FULL_THR = 3'd0;
   localparam logic [2:0] CSR_MIN_THR  = 3'd1;
   localparam logic [2:0] CSR_MAX_PCT  = 3'd2;
   localparam logic [2:0] CSR_MIN_PCT  = 3'd3;
   localparam logic [2:0] CSR_KD_PCT   = 3'd4;

   // Reset values of the configuration registers
   localparam logic [15:0] FULL_THR_RST = 16'd16384;
   localparam logic [15:0] MIN_THR_RST  = 16'd1820;
   localparam logic [6:0]  MAX_PCT_RST  = 7'd100;
   localparam logic [6:0]  MIN_PCT_RST  = 7'd20;
   localparam logic [9:0]  KD_PCT_RST   = 10'd0;

   // Percent scale and the rate term divisor (100 << 12) halved for rounding
   localparam int unsigned PCT_SCALE = 100;
   localparam int unsigned KD_HALF   = 204800;

   // Ramp branch selected by the error magnitude
   typedef enum logic [1:0] {
      SEL_MAX,
      SEL_MID,
      SEL_LOW,
      SEL_ZERO
   } ramp_sel_type;

   typedef struct packed {
      logic [15:0] full_thr;
      logic [15:0] min_thr;
      logic [6:0]  max_pct;
      logic [6:0]  min_pct;
      logic [9:0]  kd_pct;
   } cfg_type;

endpackage

// File: src/heading_pd_turn_controller.sv
// Heading PD turn controller.
// Input channel: an item (current/target heading, measured/target rate,
// forward request) is taken at a rising edge with start high and busy low.
// busy stays low: the pipeline takes a new item every cycle.
// Result channel: rsp_valid is high for one cycle with rsp_turn_power and
// rsp_forward_power; the receiver must take it then.
// Configuration: csr_write with csr_index and csr_wdata writes one register
// (0 full threshold, 1 min threshold, 2 max percent, 3 min percent,
// 4 kd percent); other indexes are ignored. Write only while no item is in
// flight.
// Pipeline: two bit-serial pipelined dividers, one stage per numerator bit:
// the ramp divide (POWER_FRAC_BITS + 31 stages) and the normalizing divide
// (2*POWER_FRAC_BITS + 14 stages), plus six arithmetic and output stages; the
// rate term is divided by a reciprocal multiply in the front stages and rides
// alongside the ramp divide.
// Throughput: one item per cycle.
// Reset: clears all valid bits, so no result comes out of items in flight, and
// loads the register defaults.
module heading_pd_turn_controller #(
   parameter int ANGLE_BITS      = 16,
   parameter int POWER_FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [15:0]          req_current_angle,
   input  logic [15:0]          req_target_angle,
   input  logic signed [19:0]   req_angular_rate,
   input  logic signed [19:0]   req_target_rate,
   input  logic signed [15:0]   req_forward_request,
   output logic                 rsp_valid,
   output logic signed [15:0]   rsp_turn_power,
   output logic signed [15:0]   rsp_forward_power,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import hpt_pkg::*;

   localparam int PF    = POWER_FRAC_BITS;
   localparam int NUM_W = PF + 31;
   localparam int DEN_W = 23;

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic                accept;

   logic                pv;
   logic [NUM_W-1:0]    ramp_num;
   logic [DEN_W-1:0]    ramp_den;
   logic                ramp_neg;
   logic [PF+11:0]      kd_q_p;
   logic                kd_neg;
   logic signed [15:0]  fwd_p;

   logic                rv;
   logic [PF:0]         ramp_q;
   logic [PF+29:0]      ramp_tag;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Write one configuration register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FULL_THR: cfg_in.full_thr = csr_wdata;
            CSR_MIN_THR:  cfg_in.min_thr  = csr_wdata;
            CSR_MAX_PCT:  cfg_in.max_pct  = csr_wdata[6:0];
            CSR_MIN_PCT:  cfg_in.min_pct  = csr_wdata[6:0];
            CSR_KD_PCT:   cfg_in.kd_pct   = csr_wdata[9:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_thr <= FULL_THR_RST;
         cfg_ff.min_thr  <= MIN_THR_RST;
         cfg_ff.max_pct  <= MAX_PCT_RST;
         cfg_ff.min_pct  <= MIN_PCT_RST;
         cfg_ff.kd_pct   <= KD_PCT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hpt_ramp #(
      .ANGLE_BITS      (ANGLE_BITS),
      .POWER_FRAC_BITS (PF),
      .NUM_W           (NUM_W),
      .DEN_W           (DEN_W)
   ) u_ramp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .in_valid           (accept),
      .in_current_angle   (req_current_angle),
      .in_target_angle    (req_target_angle),
      .in_angular_rate    (req_angular_rate),
      .in_target_rate     (req_target_rate),
      .in_forward_request (req_forward_request),
      .out_valid          (pv),
      .out_ramp_num       (ramp_num),
      .out_ramp_den       (ramp_den),
      .out_ramp_neg       (ramp_neg),
      .out_kd_q           (kd_q_p),
      .out_kd_neg         (kd_neg),
      .out_fwd            (fwd_p)
   );

   // Divide the ramp; carry the signs, rate term and forward request along
   hpt_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (PF + 1),
      .TAG_W (PF + 30)
   ) u_div_ramp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pv),
      .in_num    (ramp_num),
      .in_den    (ramp_den),
      .in_tag    ({ramp_neg, kd_q_p, kd_neg, fwd_p}),
      .out_valid (rv),
      .out_quo   (ramp_q),
      .out_tag   (ramp_tag)
   );

   hpt_norm #(
      .POWER_FRAC_BITS (PF)
   ) u_norm (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (rv),
      .in_ramp_q   (ramp_q),
      .in_ramp_neg (ramp_tag[PF+29]),
      .in_kd_q     (ramp_tag[PF+28:17]),
      .in_kd_neg   (ramp_tag[16]),
      .in_fwd      ($signed(ramp_tag[15:0])),
      .out_valid   (rsp_valid),
      .out_turn    (rsp_turn_power),
      .out_fwd     (rsp_forward_power)
   );

endmodule

// File: src/hpt_ramp.sv
module hpt_ramp #(
   parameter int ANGLE_BITS      = 16,
   parameter int POWER_FRAC_BITS = 14,
   parameter int NUM_W           = 45,
   parameter int DEN_W           = 23
) (
   input  logic                            clock,
   input  logic                            reset,
   input  hpt_pkg::cfg_type                cfg,
   input  logic                            in_valid,
   input  logic [15:0]                     in_current_angle,
   input  logic [15:0]                     in_target_angle,
   input  logic signed [19:0]              in_angular_rate,
   input  logic signed [19:0]              in_target_rate,
   input  logic signed [15:0]              in_forward_request,
   output logic                            out_valid,
   output logic [NUM_W-1:0]                out_ramp_num,
   output logic [DEN_W-1:0]                out_ramp_den,
   output logic                            out_ramp_neg,
   output logic [POWER_FRAC_BITS+11:0]     out_kd_q,
   output logic                            out_kd_neg,
   output logic signed [15:0]              out_fwd
);
   import hpt_pkg::*;

   localparam int AW    = ANGLE_BITS;
   localparam int EXT_W = (AW > 16) ? AW : 16;

   // Rate term: (100 << 12) = 16384 * 25, so shift by 14 then divide by 25
   localparam int KW   = POWER_FRAC_BITS + 17;
   localparam int KN_W = KW + 14;
   localparam int KQ_W = POWER_FRAC_BITS + 12;
   localparam int KM_W = KW + 1;
   localparam int KP_W = KW + KM_W;
   localparam int KD_S = KW + 5;
   localparam longint unsigned KD_M = ((64'd1 << KD_S) + 64'd24) / 64'd25;

   // Stage 1 signals
   logic [EXT_W-1:0]     cur_x;
   logic [EXT_W-1:0]     tgt_x;
   logic [AW-1:0]        diff;
   logic                 eneg;
   logic [AW-1:0]        dmag;
   logic [EXT_W-1:0]     d_x;
   logic [EXT_W-1:0]     t1_x;
   logic [EXT_W-1:0]     t2_x;
   logic [EXT_W-1:0]     dm_x;
   ramp_sel_type         sel1_in;
   logic [15:0]          a1_in;
   logic                 v1_ff;
   ramp_sel_type         sel1_ff;
   logic [15:0]          a1_ff;
   logic [15:0]          span1_ff;
   logic                 eneg1_ff;
   logic signed [20:0]   dv1_ff;
   logic signed [15:0]   fwd1_ff;

   // Stage 2 signals
   logic signed [7:0]    b2;
   logic signed [24:0]   p1_in;
   logic [22:0]          p2_in;
   logic [DEN_W-1:0]     den2_in;
   logic [19:0]          dvmag;
   logic [29:0]          kdp;
   logic [KN_W-1:0]      kwide;
   logic [KW-1:0]        kw2_in;
   logic                 v2_ff;
   logic signed [24:0]   p1_ff;
   logic [22:0]          p2_ff;
   logic [DEN_W-1:0]     den2_ff;
   logic                 eneg2_ff;
   logic [KW-1:0]        kw2_ff;
   logic                 dvneg2_ff;
   logic signed [15:0]   fwd2_ff;

   // Stage 3 signals
   logic signed [24:0]   sum3;
   logic [23:0]          rmag3;
   logic [KP_W-1:0]      kprod3;
   logic                 v3_ff;
   logic [NUM_W-1:0]     rnum3_ff;
   logic [DEN_W-1:0]     den3_ff;
   logic                 rneg3_ff;
   logic [KQ_W-1:0]      kq3_ff;
   logic                 kneg3_ff;
   logic signed [15:0]   fwd3_ff;

   // Wrap the heading error and pick the ramp branch
   always_comb begin
      cur_x = EXT_W'(in_current_angle);
      tgt_x = EXT_W'(in_target_angle);
      diff  = tgt_x[AW-1:0] - cur_x[AW-1:0];
      eneg  = diff > (AW'(1) << (AW - 1));
      dmag  = eneg ? (AW'(0) - diff) : diff;
      d_x   = EXT_W'(dmag);
      t1_x  = EXT_W'(cfg.full_thr);
      t2_x  = EXT_W'(cfg.min_thr);
      dm_x  = d_x - t2_x;
      priority if (d_x > t1_x) begin
         sel1_in = SEL_MAX;
         a1_in   = 16'd1;
      end else if (d_x > t2_x) begin
         sel1_in = SEL_MID;
         a1_in   = dm_x[15:0];
      end else if (cfg.min_thr == 16'd0) begin
         sel1_in = SEL_ZERO;
         a1_in   = 16'd0;
      end else begin
         sel1_in = SEL_LOW;
         a1_in   = d_x[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      sel1_ff  <= sel1_in;
      a1_ff    <= a1_in;
      span1_ff <= cfg.full_thr - cfg.min_thr;
      eneg1_ff <= eneg;
      dv1_ff   <= $signed({in_target_rate[19], in_target_rate})
                - $signed({in_angular_rate[19], in_angular_rate});
      fwd1_ff  <= in_forward_request;
   end

   // Form the ramp products, the divisor and the rounded, shifted rate product
   always_comb begin
      unique case (sel1_ff)
         SEL_MID: begin
            b2      = $signed({1'b0, cfg.max_pct}) - $signed({1'b0, cfg.min_pct});
            p2_in   = 23'(cfg.min_pct) * 23'(span1_ff);
            den2_in = DEN_W'(span1_ff) * DEN_W'(PCT_SCALE);
         end
         SEL_LOW: begin
            b2      = $signed({1'b0, cfg.min_pct});
            p2_in   = 23'd0;
            den2_in = DEN_W'(cfg.min_thr) * DEN_W'(PCT_SCALE);
         end
         SEL_MAX: begin
            b2      = $signed({1'b0, cfg.max_pct});
            p2_in   = 23'd0;
            den2_in = DEN_W'(PCT_SCALE);
         end
         default: begin
            b2      = 8'sd0;
            p2_in   = 23'd0;
            den2_in = DEN_W'(PCT_SCALE);
         end
      endcase
      p1_in  = $signed({1'b0, a1_ff}) * b2;
      dvmag  = dv1_ff[20] ? 20'(-dv1_ff) : dv1_ff[19:0];
      kdp    = 30'(dvmag) * 30'(cfg.kd_pct);
      kwide  = (KN_W'(kdp) << POWER_FRAC_BITS) + KN_W'(KD_HALF);
      kw2_in = kwide[KN_W-1:14];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      den2_ff   <= den2_in;
      eneg2_ff  <= eneg1_ff;
      kw2_ff    <= kw2_in;
      dvneg2_ff <= dv1_ff[20];
      fwd2_ff   <= fwd2_ff_next(fwd1_ff);
   end

   function automatic logic signed [15:0] fwd2_ff_next(logic signed [15:0] v);
      return v;
   endfunction

   // Scale to full power and add half the divisor; divide the rate term by 25
   always_comb begin
      sum3   = p1_ff + $signed({2'b00, p2_ff});
      rmag3  = sum3[24] ? 24'(-sum3) : sum3[23:0];
      kprod3 = KP_W'(kw2_ff) * KP_W'(KD_M);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      rnum3_ff <= (NUM_W'(rmag3) << POWER_FRAC_BITS) + NUM_W'(den2_ff >> 1);
      den3_ff  <= den2_ff;
      rneg3_ff <= sum3[24] ^ eneg2_ff;
      kq3_ff   <= kprod3[KD_S +: KQ_W];
      kneg3_ff <= dvneg2_ff;
      fwd3_ff  <= fwd2_ff;
   end

   assign out_valid    = v3_ff;
   assign out_ramp_num = rnum3_ff;
   assign out_ramp_den = den3_ff;
   assign out_ramp_neg = rneg3_ff;
   assign out_kd_q     = kq3_ff;
   assign out_kd_neg   = kneg3_ff;
   assign out_fwd      = fwd3_ff;

endmodule

// File: src/hpt_div.sv
module hpt_div #(
   parameter int NUM_W = 45,
   parameter int DEN_W = 23,
   parameter int QUO_W = 15,
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [TAG_W-1:0]  out_tag
);

   // One quotient bit per stage; the word shifts numerator bits out, quotient in
   logic              vld_ff  [1:NUM_W];
   logic [NUM_W-1:0]  word_ff [1:NUM_W];
   logic [DEN_W-1:0]  rem_ff  [1:NUM_W];
   logic [DEN_W-1:0]  den_ff  [1:NUM_W];
   logic [TAG_W-1:0]  tag_ff  [1:NUM_W];

   for (genvar s = 1; s <= NUM_W; s++) begin : g_stage
      logic              vld_src;
      logic [NUM_W-1:0]  word_src;
      logic [DEN_W-1:0]  rem_src;
      logic [DEN_W-1:0]  den_src;
      logic [TAG_W-1:0]  tag_src;
      logic [DEN_W:0]    rem_sh;
      logic [DEN_W:0]    rem_sub;
      logic              ge;

      if (s == 1) begin : g_first
         assign vld_src  = in_valid;
         assign word_src = in_num;
         assign rem_src  = '0;
         assign den_src  = in_den;
         assign tag_src  = in_tag;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign word_src = word_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign tag_src  = tag_ff[s-1];
      end

      // Shift in the next numerator bit and subtract when it fits
      always_comb begin
         rem_sh  = {rem_src, word_src[NUM_W-1]};
         rem_sub = rem_sh - {1'b0, den_src};
         ge      = rem_sh >= {1'b0, den_src};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_src;
         end
         word_ff[s] <= {word_src[NUM_W-2:0], ge};
         rem_ff[s]  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         den_ff[s]  <= den_src;
         tag_ff[s]  <= tag_src;
      end
   end

   assign out_valid = vld_ff[NUM_W];
   assign out_quo   = word_ff[NUM_W][QUO_W-1:0];
   assign out_tag   = tag_ff[NUM_W];

endmodule

// File: src/hpt_norm.sv
module hpt_norm #(
   parameter int POWER_FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [POWER_FRAC_BITS:0]      in_ramp_q,
   input  logic                          in_ramp_neg,
   input  logic [POWER_FRAC_BITS+11:0]   in_kd_q,
   input  logic                          in_kd_neg,
   input  logic signed [15:0]            in_fwd,
   output logic                          out_valid,
   output logic signed [15:0]            out_turn,
   output logic signed [15:0]            out_fwd
);

   localparam int PF = POWER_FRAC_BITS;
   localparam int TW = PF + 14;
   localparam int NN = 2 * PF + 14;
   localparam int QW = PF + 1;
   localparam int OW = (PF + 2 > 16) ? PF + 2 : 16;

   logic signed [TW-1:0]  r_s;
   logic signed [TW-1:0]  k_s;
   logic                  v4_ff;
   logic signed [TW-1:0]  turn4_ff;
   logic signed [15:0]    fwd4_ff;

   logic [TW-1:0]         tmag;
   logic [16:0]           fmag17;
   logic [TW-1:0]         total;
   logic [TW-1:0]         full;
   logic [TW-1:0]         den5;
   logic                  v5_ff;
   logic [NN-1:0]         tnum5_ff;
   logic [NN-1:0]         fnum5_ff;
   logic [TW-1:0]         den5_ff;
   logic                  tneg5_ff;
   logic                  fneg5_ff;

   logic                  tv;
   logic                  fv;
   logic [QW-1:0]         tq;
   logic [QW-1:0]         fq;
   logic                  tneg;
   logic                  fneg;
   logic [OW-1:0]         tval;
   logic [OW-1:0]         fval;
   logic                  vo_ff;
   logic signed [15:0]    turn_o_ff;
   logic signed [15:0]    fwd_o_ff;

   // Add the signed ramp and rate terms
   always_comb begin
      r_s = in_ramp_neg ? -$signed(TW'(in_ramp_q)) : $signed(TW'(in_ramp_q));
      k_s = in_kd_neg ? -$signed(TW'(in_kd_q)) : $signed(TW'(in_kd_q));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= in_valid;
      end
      turn4_ff <= r_s + k_s;
      fwd4_ff  <= in_fwd;
   end

   // Pick the normalizing divisor: the magnitude sum above full scale, else full scale
   always_comb begin
      tmag   = turn4_ff[TW-1] ? TW'(-turn4_ff) : TW'(turn4_ff);
      fmag17 = fwd4_ff[15] ? 17'(-$signed({fwd4_ff[15], fwd4_ff}))
                           : 17'($signed({fwd4_ff[15], fwd4_ff}));
      total  = tmag + TW'(fmag17);
      full   = TW'(1) << PF;
      den5   = (total > full) ? total : full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      tnum5_ff <= (NN'(tmag) << PF) + NN'(den5 >> 1);
      fnum5_ff <= (NN'(fmag17) << PF) + NN'(den5 >> 1);
      den5_ff  <= den5;
      tneg5_ff <= turn4_ff[TW-1];
      fneg5_ff <= fwd4_ff[15];
   end

   hpt_div #(
      .NUM_W (NN),
      .DEN_W (TW),
      .QUO_W (QW),
      .TAG_W (1)
   ) u_div_turn (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_num    (tnum5_ff),
      .in_den    (den5_ff),
      .in_tag    (tneg5_ff),
      .out_valid (tv),
      .out_quo   (tq),
      .out_tag   (tneg)
   );

   hpt_div #(
      .NUM_W (NN),
      .DEN_W (TW),
      .QUO_W (QW),
      .TAG_W (1)
   ) u_div_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_num    (fnum5_ff),
      .in_den    (den5_ff),
      .in_tag    (fneg5_ff),
      .out_valid (fv),
      .out_quo   (fq),
      .out_tag   (fneg)
   );

   // Restore signs and truncate to the result width
   always_comb begin
      tval = tneg ? (OW'(0) - OW'(tq)) : OW'(tq);
      fval = fneg ? (OW'(0) - OW'(fq)) : OW'(fq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= tv & fv;
      end
      turn_o_ff <= $signed(tval[15:0]);
      fwd_o_ff  <= $signed(fval[15:0]);
   end

   assign out_valid = vo_ff;
   assign out_turn  = turn_o_ff;
   assign out_fwd   = fwd_o_ff;

endmodule

// File: src/hpt_checker.sv
module hpt_port_checker #(
   parameter int POWER_FRAC_BITS = 14
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic signed [15:0]  rsp_turn_power,
   input logic signed [15:0]  rsp_forward_power
);

   localparam int LAT   = 3 * POWER_FRAC_BITS + 51;
   localparam int CNT_W = $clog2(LAT + 2);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(LAT + 1);
   localparam int FULL  = 1 << POWER_FRAC_BITS;

   logic [CNT_W-1:0] cnt_ff;

   // Count clean cycles since reset, saturating past the latency
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cnt_ff != CNT_TOP) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // Pipeline never pushes back
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // Reset flushes all items in flight
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

   // Exactly one result per accepted item, at the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CNT_TOP) |-> (rsp_valid == $past(start && !busy, LAT)))
      else $error("result count or latency mismatch");

   // Normalized outputs stay within full scale
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((POWER_FRAC_BITS > 14) ||
         ((rsp_turn_power >= -FULL) && (rsp_turn_power <= FULL) &&
          (rsp_forward_power >= -FULL) && (rsp_forward_power <= FULL))))
      else $error("output beyond full scale");

endmodule

bind heading_pd_turn_controller hpt_port_checker #(
   .POWER_FRAC_BITS (POWER_FRAC_BITS)
) u_hpt_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_turn_power    (rsp_turn_power),
   .rsp_forward_power (rsp_forward_power)
);
